/* rtl/sgcb_pkg.sv */
// Shared constants and types for the Sobel gradient unit with clamped borders.
`default_nettype none

package sgcb_pkg;

    localparam int DEF_MAX_WIDTH   = 2048;
    localparam int DEF_MAX_HEIGHT  = 4096;
    localparam int DEF_SAMPLE_BITS = 12;

    localparam int SAMPLE_W     = 12;
    localparam int COL_W        = 11;
    localparam int ROW_W        = 12;
    localparam int GRAD_W       = 15;
    localparam int CFG_WIDTH_W  = 12;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_DATA_W   = 13;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    localparam int FLAGS_W = 4;

    typedef enum logic [0:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_index_t;

    // Border cells that one interior cell also feeds.
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } border_flags_t;

endpackage

`default_nettype wire

/* rtl/sgcb_queue.sv */
// Short queue of classified items between the front and back parts.
`default_nettype none

module sgcb_queue #(
    parameter int DATA_W = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire logic [DATA_W-1:0]             push_data,
    input  wire logic                          pop,
    output logic      [DATA_W-1:0]             head,
    output logic                               empty,
    output logic      [sgcb_pkg::QUEUE_CW-1:0] count
);
    import sgcb_pkg::*;

    logic [DATA_W-1:0]   store_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg;
    logic [QUEUE_CW-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + QUEUE_CW'(push) - QUEUE_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = store_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule

`default_nettype wire

/* rtl/sgcb_front.sv */
// Front part: position counters, line memory, 3x3 window, gradients and border flags.
`default_nettype none

module sgcb_front #(
    parameter int MAX_WIDTH   = 2048,
    parameter int MAX_HEIGHT  = 4096,
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [sgcb_pkg::SAMPLE_W-1:0]       sample,
    input  wire logic                                frame_start,
    input  wire logic [$clog2(MAX_WIDTH):0]          dim_w,
    input  wire logic [$clog2(MAX_HEIGHT):0]         dim_h,
    input  wire logic [sgcb_pkg::QUEUE_CW-1:0]       q_count,
    output logic                                     push,
    output logic      [sgcb_pkg::GRAD_W-1:0]         push_gx,
    output logic      [sgcb_pkg::GRAD_W-1:0]         push_gy,
    output logic      [$clog2(MAX_HEIGHT)-1:0]       push_rr,
    output logic      [$clog2(MAX_WIDTH)-1:0]        push_cc,
    output sgcb_pkg::border_flags_t                  push_flags
);
    import sgcb_pkg::*;

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int SW   = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int CALC = SW + 4;

    logic [AW-1:0] col_reg;
    logic [AW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;

    logic          accept;
    logic [AW-1:0] c0;
    logic [AW-1:0] c1;
    logic [RW-1:0] r0;
    logic [RW:0]   r0p;
    logic [RW-1:0] r2;
    logic [AW:0]   c_inc;
    logic [RW:0]   r_inc;
    logic          c_wrap;
    logic          emit;
    logic [RW-1:0] rr;
    logic [AW-1:0] cc;
    border_flags_t flags;

    logic                s1_valid_reg;
    logic                s1_emit_reg;
    logic [AW-1:0]       s1_col_reg;
    logic [SW-1:0]       s1_samp_reg;
    logic [RW-1:0]       s1_rr_reg;
    logic [AW-1:0]       s1_cc_reg;
    border_flags_t       s1_flags_reg;
    logic [2*SW-1:0]     rd_reg;
    logic                byp_hit_reg;
    logic [2*SW-1:0]     byp_data_reg;
    logic [2*SW-1:0]     line_cur;
    logic [SW-1:0]       above_cur;
    logic [SW-1:0]       two_above_cur;

    logic [2*SW-1:0]     line_mem [MAX_WIDTH];
    logic [SW-1:0]       win_reg [9];

    logic                s2_emit_reg;
    logic [RW-1:0]       s2_rr_reg;
    logic [AW-1:0]       s2_cc_reg;
    border_flags_t       s2_flags_reg;

    logic signed [CALC-1:0] v [9];
    logic signed [CALC-1:0] gx;
    logic signed [CALC-1:0] gy;

    // Position of the incoming item and of the one after it.
    always_comb
    begin
        c0     = frame_start ? '0 : col_reg;
        r0     = frame_start ? '0 : row_reg;
        c_wrap = ({1'b0, c0} >= dim_w);
        c1     = c_wrap ? '0 : c0;
        r0p    = {1'b0, r0} + (RW + 1)'(c_wrap);
        r2     = (r0p >= dim_h) ? '0 : r0p[RW-1:0];
        c_inc  = {1'b0, c1} + (AW + 1)'(1);
        r_inc  = {1'b0, r2} + (RW + 1)'(1);
        if (c_inc >= dim_w)
        begin
            col_next = '0;
            row_next = (r_inc >= dim_h) ? '0 : r_inc[RW-1:0];
        end
        else
        begin
            col_next = c_inc[AW-1:0];
            row_next = r2;
        end
        emit         = (r2 >= RW'(2)) && (c1 >= AW'(2));
        rr           = r2 - RW'(1);
        cc           = c1 - AW'(1);
        flags.top    = (rr == RW'(1));
        flags.bottom = ({1'b0, rr} == dim_h - (RW + 1)'(2)) && !flags.top;
        flags.left   = (cc == AW'(1));
        flags.right  = ({1'b0, cc} == dim_w - (AW + 1)'(2)) && !flags.left;
    end

    assign in_stall = (q_count + QUEUE_CW'(s1_emit_reg) + QUEUE_CW'(s2_emit_reg))
                      >= QUEUE_CW'(QUEUE_DEPTH);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        line_cur      = byp_hit_reg ? byp_data_reg : rd_reg;
        above_cur     = line_cur[2*SW-1:SW];
        two_above_cur = line_cur[SW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
            s2_emit_reg  <= 1'b0;
            byp_hit_reg  <= 1'b0;
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else
        begin
            s1_valid_reg <= accept;
            s1_emit_reg  <= accept && emit;
            s2_emit_reg  <= s1_emit_reg;
            if (accept)
            begin
                col_reg     <= col_next;
                row_reg     <= row_next;
                byp_hit_reg <= s1_valid_reg && (s1_col_reg == c1);
            end
            if (s1_valid_reg)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[3*k]     <= win_reg[3*k + 1];
                    win_reg[3*k + 1] <= win_reg[3*k + 2];
                end
                win_reg[2] <= two_above_cur;
                win_reg[5] <= above_cur;
                win_reg[8] <= s1_samp_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg   <= c1;
            s1_samp_reg  <= sample[SW-1:0];
            s1_rr_reg    <= rr;
            s1_cc_reg    <= cc;
            s1_flags_reg <= flags;
            byp_data_reg <= {s1_samp_reg, above_cur};
        end
        s2_rr_reg    <= s1_rr_reg;
        s2_cc_reg    <= s1_cc_reg;
        s2_flags_reg <= s1_flags_reg;
    end

    // Each entry holds the row above in its upper half and the row two above in its lower half.
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            line_mem[s1_col_reg] <= {s1_samp_reg, above_cur};
        end
        if (accept)
        begin
            rd_reg <= line_mem[c1];
        end
    end

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            v[k] = $signed(CALC'(win_reg[k]));
        end
        gx = (v[5] <<< 1) - (v[3] <<< 1) + v[8] + v[2] - v[6] - v[0];
        gy = (v[7] <<< 1) - (v[1] <<< 1) + v[6] + v[8] - v[0] - v[2];
    end

    assign push       = s2_emit_reg;
    assign push_gx    = GRAD_W'(gx);
    assign push_gy    = GRAD_W'(gy);
    assign push_rr    = s2_rr_reg;
    assign push_cc    = s2_cc_reg;
    assign push_flags = s2_flags_reg;

endmodule

`default_nettype wire

/* rtl/sgcb_back.sv */
// Back part: expands each queued item into its border results and holds the output register.
`default_nettype none

module sgcb_back #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              q_empty,
    input  wire logic [sgcb_pkg::GRAD_W-1:0]       head_gx,
    input  wire logic [sgcb_pkg::GRAD_W-1:0]       head_gy,
    input  wire logic [$clog2(MAX_HEIGHT)-1:0]     head_rr,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]      head_cc,
    input  wire sgcb_pkg::border_flags_t           head_flags,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]      w_last,
    input  wire logic [$clog2(MAX_HEIGHT)-1:0]     h_last,
    output logic                                   pop,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [sgcb_pkg::COL_W-1:0]        col,
    output logic      [sgcb_pkg::ROW_W-1:0]        row,
    output logic      [sgcb_pkg::GRAD_W-1:0]       grad_x,
    output logic      [sgcb_pkg::GRAD_W-1:0]       grad_y,
    output logic                                   last
);
    import sgcb_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic              i_reg;
    logic              i_next;
    logic              j_reg;
    logic              j_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [GRAD_W-1:0] gx_reg;
    logic [GRAD_W-1:0] gy_reg;
    logic              last_reg;

    logic          load;
    logic          two_rows;
    logic          two_cols;
    logic          last_row;
    logic          last_col;
    logic [RW-1:0] row_sel;
    logic [AW-1:0] col_sel;

    always_comb
    begin
        two_rows = head_flags.top || head_flags.bottom;
        two_cols = head_flags.left || head_flags.right;
        last_row = i_reg || !two_rows;
        last_col = j_reg || !two_cols;
        if (i_reg)
        begin
            row_sel = head_flags.top ? head_rr : h_last;
        end
        else
        begin
            row_sel = head_flags.top ? '0 : head_rr;
        end
        if (j_reg)
        begin
            col_sel = head_flags.left ? head_cc : w_last;
        end
        else
        begin
            col_sel = head_flags.left ? '0 : head_cc;
        end

        load = !q_empty && (!out_valid_reg || !out_stall);
        pop  = load && last_row && last_col;

        i_next = i_reg;
        j_next = j_reg;
        if (load)
        begin
            if (last_col)
            begin
                j_next = 1'b0;
                i_next = last_row ? 1'b0 : 1'b1;
            end
            else
            begin
                j_next = 1'b1;
            end
        end

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg         <= 1'b0;
            j_reg         <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            i_reg         <= i_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            col_reg  <= COL_W'(col_sel);
            row_reg  <= ROW_W'(row_sel);
            gx_reg   <= head_gx;
            gy_reg   <= head_gy;
            last_reg <= last_row && last_col;
        end
    end

    assign out_valid = out_valid_reg;
    assign col       = col_reg;
    assign row       = row_reg;
    assign grad_x    = gx_reg;
    assign grad_y    = gy_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

/* rtl/sobel_gradient_clamped_border_unit.sv */
// Top level of the streaming 3x3 Sobel gradient unit with clamped borders.
`default_nettype none

// Samples enter in raster order, one item per clock, and results leave at up to one per
// clock, each result tagged with its column and row; gradients are scaled by 8. The first
// result of an item passes through the front pipeline, the queue and the output register.
// Interior cells give one result per item, so the unit keeps full rate there; an item at
// an edge or corner gives two or four results, and the four-entry queue between the front
// and back parts then holds off the input while the back part drains it. The line memory
// is read once and written once per item, and a read and a write may fall in the same
// cycle. Grid size registers may only be written while the unit is idle.
module sobel_gradient_clamped_border_unit #(
    parameter int MAX_WIDTH   = sgcb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = sgcb_pkg::DEF_MAX_HEIGHT,
    parameter int SAMPLE_BITS = sgcb_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire sgcb_pkg::reg_index_t              cfg_index,
    input  wire logic [sgcb_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [sgcb_pkg::SAMPLE_W-1:0]     sample,
    input  wire logic                              frame_start,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [sgcb_pkg::COL_W-1:0]        col,
    output logic      [sgcb_pkg::ROW_W-1:0]        row,
    output logic      [sgcb_pkg::GRAD_W-1:0]       grad_x,
    output logic      [sgcb_pkg::GRAD_W-1:0]       grad_y,
    output logic                                   last
);
    import sgcb_pkg::*;

    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int WCMP   = (AW + 1 > CFG_WIDTH_W) ? AW + 1 : CFG_WIDTH_W;
    localparam int HCMP   = (RW + 1 > CFG_HEIGHT_W) ? RW + 1 : CFG_HEIGHT_W;
    localparam int ENTRY_W = 2 * GRAD_W + RW + AW + FLAGS_W;

    logic [CFG_WIDTH_W-1:0]  width_reg;
    logic [CFG_HEIGHT_W-1:0] height_reg;
    logic [WCMP-1:0]         w_ext;
    logic [HCMP-1:0]         h_ext;
    logic [AW:0]             dim_w;
    logic [RW:0]             dim_h;
    logic [AW-1:0]           w_last;
    logic [RW-1:0]           h_last;

    logic                push;
    logic [GRAD_W-1:0]   push_gx;
    logic [GRAD_W-1:0]   push_gy;
    logic [RW-1:0]       push_rr;
    logic [AW-1:0]       push_cc;
    border_flags_t       push_flags;
    logic [ENTRY_W-1:0]  push_data;
    logic [ENTRY_W-1:0]  head;
    logic                q_empty;
    logic [QUEUE_CW-1:0] q_count;
    logic                pop;

    logic [GRAD_W-1:0]   head_gx;
    logic [GRAD_W-1:0]   head_gy;
    logic [RW-1:0]       head_rr;
    logic [AW-1:0]       head_cc;
    border_flags_t       head_flags;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_WIDTH_W'(2048);
            height_reg <= CFG_HEIGHT_W'(2048);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[CFG_WIDTH_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[CFG_HEIGHT_W-1:0];
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        w_ext = WCMP'(width_reg);
        h_ext = HCMP'(height_reg);
        if (w_ext < WCMP'(3))
        begin
            dim_w = (AW + 1)'(3);
        end
        else if (w_ext > WCMP'(MAX_WIDTH))
        begin
            dim_w = (AW + 1)'(MAX_WIDTH);
        end
        else
        begin
            dim_w = (AW + 1)'(w_ext);
        end
        if (h_ext < HCMP'(3))
        begin
            dim_h = (RW + 1)'(3);
        end
        else if (h_ext > HCMP'(MAX_HEIGHT))
        begin
            dim_h = (RW + 1)'(MAX_HEIGHT);
        end
        else
        begin
            dim_h = (RW + 1)'(h_ext);
        end
        w_last = AW'(dim_w - (AW + 1)'(1));
        h_last = RW'(dim_h - (RW + 1)'(1));
    end

    sgcb_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .frame_start (frame_start),
        .dim_w       (dim_w),
        .dim_h       (dim_h),
        .q_count     (q_count),
        .push        (push),
        .push_gx     (push_gx),
        .push_gy     (push_gy),
        .push_rr     (push_rr),
        .push_cc     (push_cc),
        .push_flags  (push_flags)
    );

    assign push_data = {push_gx, push_gy, push_rr, push_cc, push_flags};

    sgcb_queue #(
        .DATA_W (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .count     (q_count)
    );

    assign {head_gx, head_gy, head_rr, head_cc, head_flags} = head;

    sgcb_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .head_gx    (head_gx),
        .head_gy    (head_gy),
        .head_rr    (head_rr),
        .head_cc    (head_cc),
        .head_flags (head_flags),
        .w_last     (w_last),
        .h_last     (h_last),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .col        (col),
        .row        (row),
        .grad_x     (grad_x),
        .grad_y     (grad_y),
        .last       (last)
    );

endmodule

`default_nettype wire
